[rtl/reversible_circular_deque_unit_assert.svh]
// assertion macros used by the deque rtl
`ifndef REVERSIBLE_CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define REVERSIBLE_CIRCULAR_DEQUE_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define RCDQ_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rcdq assertion failed");

// condition must hold in the cycle after the trigger
`define RCDQ_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rcdq assertion failed");

`endif

[rtl/rcdq_pkg.sv]
`default_nettype none

package rcdq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes, codes 9 to 15 are no-ops
    typedef enum logic [3:0] {
        KIND_PUSH_BACK  = 4'd0,
        KIND_PUSH_FRONT = 4'd1,
        KIND_POP_BACK   = 4'd2,
        KIND_POP_FRONT  = 4'd3,
        KIND_READ       = 4'd4,
        KIND_WRITE      = 4'd5,
        KIND_REVERSE    = 4'd6,
        KIND_SEARCH     = 4'd7,
        KIND_CLEAR      = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [5:0]  position;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_data;
        logic        found;
        logic [5:0]  found_position;
        logic [6:0]  count;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/reversible_circular_deque_unit.sv]
`default_nettype none

// channel | direction | handshake               | payload
// --------+-----------+-------------------------+----------------------------------
// req     | in        | req_valid / req_ready   | rcdq_pkg::req_t (kind, value, pos)
// rsp     | out       | rsp_valid / rsp_ready   | rcdq_pkg::rsp_t (one per request)
//
// push, pop, write, reverse, clear and no-op answer from the idle state; read
// passes through S_READ (one registered read of the element memory); search
// steps through S_SCAN from logical index 0 up to the first match or the last
// element and answers at once when empty, one memory read per element scanned
// reset clears head, tail, occupancy, the reverse flag and the sequencer; the
// element memory is not cleared, an entry is only read after it was written
// req_ready is low while a read or search is in flight, and while the response
// register is full and rsp_ready is low

`include "reversible_circular_deque_unit_assert.svh"

module reversible_circular_deque_unit #(
    parameter int CAPACITY   = rcdq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = rcdq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire rcdq_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output rcdq_pkg::rsp_t       rsp
);

    localparam int AW = $clog2(CAPACITY);      // physical slot index width
    localparam int SW = AW + 1;                // wrap arithmetic width
    localparam int OW = $clog2(CAPACITY + 1);  // occupancy width

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    // element store, single write port and registered read port
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata_reg;

    // control state
    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;   // physical first element (unreversed)
    logic [AW-1:0] tail_reg, tail_next;   // physical slot after the last element
    logic [OW-1:0] occ_reg, occ_next;
    logic          flip_reg, flip_next;
    logic [OW-1:0] scan_idx_reg, scan_idx_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload holding registers
    rcdq_pkg::req_t op_reg;
    rcdq_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_load;

    logic req_fire;
    logic is_full;
    logic is_empty;
    logic pos_in_range;
    logic scan_hit;
    logic scan_last;

    // logical index to physical slot, reversed order counts back from tail
    function automatic logic [AW-1:0] phys_of(
        input logic [AW-1:0] lidx,
        input logic [AW-1:0] hd,
        input logic [AW-1:0] tl,
        input logic          flp
    );
        logic [SW-1:0] s;
        if (flp) begin
            s = {1'b0, tl} + SW'(CAPACITY - 1) - {1'b0, lidx};
        end else begin
            s = {1'b0, hd} + {1'b0, lidx};
        end
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] x);
        return (x == AW'(CAPACITY - 1)) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] x);
        return (x == '0) ? AW'(CAPACITY - 1) : x - AW'(1);
    endfunction

    // a new transaction is taken only in idle when the response register is empty
    // or frees up by the same edge, so ops handled in idle can answer at once
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_full      = (occ_reg == OW'(CAPACITY));
    assign is_empty     = (occ_reg == '0);
    assign pos_in_range = (32'(req.position) < 32'(occ_reg));

    // scan compares the element read in the previous cycle
    assign scan_hit  = (mem_rdata_reg == DATA_WIDTH'(op_reg.value));
    assign scan_last = ((scan_idx_reg + OW'(1)) == occ_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        flip_next      = flip_reg;
        scan_idx_next  = scan_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_load       = 1'b0;
        rsp_next       = '0;
        mem_we         = 1'b0;
        mem_waddr      = tail_reg;
        mem_wdata      = DATA_WIDTH'(req.value);
        mem_re         = 1'b0;
        mem_raddr      = phys_of(AW'(req.position), head_reg, tail_reg, flip_reg);

        if (rsp_valid_reg && rsp_ready) begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire) begin
                    rsp_load        = 1'b1;
                    rsp_next.status = rcdq_pkg::STATUS_OK;
                    case (req.kind) inside
                        rcdq_pkg::KIND_PUSH_BACK, rcdq_pkg::KIND_PUSH_FRONT:
                        begin
                            if (is_full) begin
                                rsp_next.status = rcdq_pkg::STATUS_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                occ_next = occ_reg + OW'(1);
                                if ((req.kind == rcdq_pkg::KIND_PUSH_BACK) != flip_reg) begin
                                    mem_waddr = tail_reg;
                                    tail_next = slot_inc(tail_reg);
                                end else begin
                                    mem_waddr = slot_dec(head_reg);
                                    head_next = slot_dec(head_reg);
                                end
                            end
                        end
                        rcdq_pkg::KIND_POP_BACK, rcdq_pkg::KIND_POP_FRONT:
                        begin
                            if (is_empty) begin
                                rsp_next.status = rcdq_pkg::STATUS_EMPTY;
                            end else begin
                                occ_next = occ_reg - OW'(1);
                                if ((req.kind == rcdq_pkg::KIND_POP_BACK) != flip_reg) begin
                                    tail_next = slot_dec(tail_reg);
                                end else begin
                                    head_next = slot_inc(head_reg);
                                end
                            end
                        end
                        rcdq_pkg::KIND_READ:
                        begin
                            if (!pos_in_range) begin
                                rsp_next.status = rcdq_pkg::STATUS_RANGE;
                            end else begin
                                // answer once the memory data is back
                                rsp_load   = 1'b0;
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        rcdq_pkg::KIND_WRITE:
                        begin
                            if (!pos_in_range) begin
                                rsp_next.status = rcdq_pkg::STATUS_RANGE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = phys_of(AW'(req.position), head_reg, tail_reg,
                                                    flip_reg);
                            end
                        end
                        rcdq_pkg::KIND_REVERSE:
                        begin
                            flip_next = !flip_reg;
                        end
                        rcdq_pkg::KIND_SEARCH:
                        begin
                            if (!is_empty) begin
                                rsp_load      = 1'b0;
                                mem_re        = 1'b1;
                                mem_raddr     = phys_of('0, head_reg, tail_reg, flip_reg);
                                scan_idx_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        rcdq_pkg::KIND_CLEAR:
                        begin
                            head_next = '0;
                            tail_next = '0;
                            occ_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.count = 7'(occ_next);
                    if (rsp_load) begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                rsp_load           = 1'b1;
                rsp_next.status    = rcdq_pkg::STATUS_OK;
                rsp_next.read_data = 32'(mem_rdata_reg);
                rsp_next.count     = 7'(occ_reg);
                rsp_valid_next     = 1'b1;
                state_next         = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_hit || scan_last) begin
                    rsp_load                = 1'b1;
                    rsp_next.status         = rcdq_pkg::STATUS_OK;
                    rsp_next.found          = scan_hit;
                    rsp_next.found_position = scan_hit ? 6'(scan_idx_reg) : '0;
                    rsp_next.count          = 7'(occ_reg);
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end else begin
                    // fetch the next logical element
                    mem_re        = 1'b1;
                    mem_raddr     = phys_of(AW'(scan_idx_reg + OW'(1)), head_reg, tail_reg,
                                            flip_reg);
                    scan_idx_next = scan_idx_reg + OW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            flip_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            flip_reg      <= flip_next;
            scan_idx_reg  <= scan_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire) begin
            op_reg <= req;
        end
        if (rsp_load) begin
            rsp_reg <= rsp_next;
        end
    end

    // element memory
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // tail always sits occupancy slots past head
    `RCDQ_ASSERT_NOW(a_tail_tracks_head, 1'b1,
        32'(tail_reg) == ((32'(head_reg) + 32'(occ_reg) >= 32'(CAPACITY)) ?
            (32'(head_reg) + 32'(occ_reg) - 32'(CAPACITY)) :
            (32'(head_reg) + 32'(occ_reg))))
    // nothing waits in the response register while a read or scan is in flight
    `RCDQ_ASSERT_NOW(a_busy_no_rsp, state_reg != S_IDLE, !rsp_valid_reg)
    // the scan never runs past the stored elements
    `RCDQ_ASSERT_NOW(a_scan_in_range, state_reg == S_SCAN, scan_idx_reg < occ_reg)
    // every accepted transaction either answers at once or keeps the sequencer busy
    `RCDQ_ASSERT_NEXT(a_req_progress, req_fire, rsp_valid_reg || state_reg != S_IDLE)

endmodule

`default_nettype wire
